// File: rtl/bsa_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes for the bitmap slot allocator.
// -----------------------------------------------------------------------------
package bsa_pkg;

   // Bitmap word geometry
   localparam int WORD_BITS = 8;
   localparam logic [WORD_BITS-1:0] WORD_FULL = 8'hFF;

   // Command codes
   localparam logic CMD_CLONE  = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Status codes
   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_FULL   = 3'd1;
   localparam logic [2:0] STAT_EMPTY  = 3'd2;
   localparam logic [2:0] STAT_RANGE  = 3'd3;
   localparam logic [2:0] STAT_ABSENT = 3'd4;

   // Request transaction
   typedef struct packed {
      logic       command;
      logic [7:0] index;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [7:0] new_slot;
      logic [7:0] copy_source;
      logic [2:0] status;
      logic [8:0] live_count;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/bitmap_slot_allocator_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bitmap_slot_allocator_unit
// Slot allocator over an occupancy bitmap with a lowest-free hint and count.
//
//   channel  direction  handshake           payload
//   req_     in         req_valid/req_stall bsa_pkg::req_type (command, index)
//   rsp_     out        rsp_valid/rsp_stall bsa_pkg::rsp_type (slot, src, status, count)
//
// A command passes through accept, bitmap word check and hand-off to the
// response register; a clone that fills its bitmap word also runs the
// next-free scan over the further 8-slot words, at most (SLOTS+7)/8 - 1.
// After reset a clearing pass writes every bitmap word, (SLOTS+7)/8 words
// (32 at 256 slots), with req_stall high.
// The response register lets a command start while the last response waits.
// -----------------------------------------------------------------------------
module bitmap_slot_allocator_unit #(
   parameter int SLOTS = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bsa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bsa_pkg::rsp_type      rsp_data
);
   import bsa_pkg::*;

   // last word may hold unused padding bits above SLOTS
   localparam int WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int HW    = $clog2(SLOTS + 1);

   logic          idle;
   logic          req_accept;
   logic          res_valid;
   logic          res_take;
   rsp_type       res_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_a_addr;
   logic [AW-1:0] rd_b_addr;
   logic [7:0]    rd_a_data;
   logic [7:0]    rd_b_data;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   assign req_stall  = !idle;
   assign req_accept = req_valid && idle;

   bsa_ctrl #(
      .SLOTS (SLOTS),
      .WORDS (WORDS),
      .AW    (AW),
      .HW    (HW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .idle       (idle),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res_data   (res_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_a_addr  (rd_a_addr),
      .rd_b_addr  (rd_b_addr),
      .rd_a_data  (rd_a_data),
      .rd_b_data  (rd_b_data)
   );

   bsa_bitmap_ram #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_bitmap (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // Response register
   always_comb begin
      res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// File: rtl/bsa_bitmap_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsa_bitmap_ram
// Occupancy bitmap store: one write port, two registered read ports.
// -----------------------------------------------------------------------------
module bsa_bitmap_ram #(
   parameter int WORDS = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_a_addr,
   input  wire logic [AW-1:0] rd_b_addr,
   output logic [7:0]         rd_a_data,
   output logic [7:0]         rd_b_data
);
   logic [7:0] mem [WORDS];
   logic [7:0] rd_a_data_ff;
   logic [7:0] rd_b_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports, registered
   always_ff @(posedge clock) begin
      rd_a_data_ff <= mem[rd_a_addr];
      rd_b_data_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule
`default_nettype wire

// File: rtl/bsa_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsa_ctrl
// Command sequencer: reset clear pass, checks, read-modify-write of bitmap words, hint rescan.
// -----------------------------------------------------------------------------
module bsa_ctrl #(
   parameter int SLOTS = 256,
   parameter int WORDS = 32,
   parameter int AW    = 5,
   parameter int HW    = 9
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_accept,
   input  wire bsa_pkg::req_type req_data,
   output logic                  idle,
   output logic                  res_valid,
   input  wire logic             res_take,
   output bsa_pkg::rsp_type      res_data,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [7:0]            wr_data,
   output logic [AW-1:0]         rd_a_addr,
   output logic [AW-1:0]         rd_b_addr,
   input  wire logic [7:0]       rd_a_data,
   input  wire logic [7:0]       rd_b_data
);
   import bsa_pkg::*;

   localparam int IW = (HW > 8) ? HW : 8;
   localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
   localparam logic [HW-1:0] HINT_NONE = HW'(SLOTS);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Lowest clear bit of a word: {found, position}
   function automatic logic [3:0] first_zero(input logic [7:0] w);
      logic [3:0] r;
      r = 4'b0000;
      for (int i = 7; i >= 0; i--) begin
         if (!w[i]) begin
            r = {1'b1, 3'(i)};
         end
      end
      return r;
   endfunction

   state_type     state_ff, state_in;
   logic          cmd_ff, cmd_in;
   logic [7:0]    idx_ff, idx_in;
   logic [HW-1:0] hint_ff, hint_in;
   logic [HW-1:0] count_ff, count_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic [AW-1:0] clr_ff, clr_in;
   rsp_type       res_ff, res_in;

   logic [IW-1:0] idx_ext;
   logic [IW-1:0] req_idx_ext;
   logic          idx_ok;
   logic          src_bit;
   logic [AW-1:0] hint_word;
   logic [7:0]    hint_word_new;
   logic [3:0]    fz_hint;
   logic [3:0]    fz_scan;

   // Address and hit decode
   always_comb begin
      idx_ext       = IW'(idx_ff);
      req_idx_ext   = IW'(req_data.index);
      idx_ok        = idx_ext < IW'(SLOTS);
      src_bit       = rd_a_data[idx_ff[2:0]];
      hint_word     = hint_ff[AW+2:3];
      hint_word_new = rd_b_data | (8'b1 << hint_ff[2:0]);
      fz_hint       = first_zero(hint_word_new);
      fz_scan       = first_zero(rd_b_data);
      rd_a_addr     = req_idx_ext[AW+2:3];
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      hint_in   = hint_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      clr_in    = clr_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = hint_word;
      wr_data   = hint_word_new;
      rd_b_addr = hint_word;
      idle      = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            idle = 1'b1;
            if (req_accept) begin
               cmd_in   = req_data.command;
               idx_in   = req_data.index;
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            res_in.new_slot    = '0;
            res_in.copy_source = '0;
            res_in.live_count  = 9'(count_ff);
            state_in           = ST_DONE;
            if (cmd_ff == CMD_CLONE) begin
               if (hint_ff >= HINT_NONE) begin
                  res_in.status = STAT_FULL;
               end else if (!idx_ok) begin
                  res_in.status = STAT_RANGE;
               end else if (!src_bit) begin
                  res_in.status = STAT_EMPTY;
               end else begin
                  // claim the hinted slot and look for the next free one
                  wr_en              = 1'b1;
                  count_in           = count_ff + HW'(1);
                  res_in.status      = STAT_OK;
                  res_in.new_slot    = 8'(hint_ff);
                  res_in.copy_source = idx_ff;
                  res_in.live_count  = 9'(count_ff + HW'(1));
                  rd_b_addr          = hint_word + AW'(1);
                  if (fz_hint[3]) begin
                     hint_in = HW'({hint_word, fz_hint[2:0]});
                  end else if (hint_word == LAST_WORD) begin
                     hint_in = HINT_NONE;
                  end else begin
                     scan_in  = hint_word + AW'(1);
                     state_in = ST_SCAN;
                  end
               end
            end else begin
               if (!idx_ok) begin
                  res_in.status = STAT_RANGE;
               end else if (!src_bit) begin
                  res_in.status = STAT_ABSENT;
               end else begin
                  // free the slot, pull the hint down
                  wr_en             = 1'b1;
                  wr_addr           = idx_ext[AW+2:3];
                  wr_data           = rd_a_data & ~(8'b1 << idx_ff[2:0]);
                  count_in          = count_ff - HW'(1);
                  res_in.status     = STAT_OK;
                  res_in.live_count = 9'(count_ff - HW'(1));
                  if (hint_ff > HW'(idx_ext)) begin
                     hint_in = HW'(idx_ext);
                  end
               end
            end
         end

         ST_SCAN: begin
            // one bitmap word per cycle, next read issued ahead
            rd_b_addr = scan_ff + AW'(1);
            if (rd_b_data != WORD_FULL) begin
               hint_in  = HW'({scan_ff, fz_scan[2:0]});
               state_in = ST_DONE;
            end else if (scan_ff == LAST_WORD) begin
               hint_in  = HINT_NONE;
               state_in = ST_DONE;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         hint_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         hint_ff  <= hint_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      scan_ff <= scan_in;
      res_ff  <= res_in;
   end

   assign res_data = res_ff;

endmodule
`default_nettype wire
